// File: rtl/grb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_pkg
// Shared types, codes and defaults for the glyph row blitter.
// ----------------------------------------------------------------------------
package grb_pkg;

    localparam int DEF_GLYPH_ROWS  = 16;
    localparam int DEF_GLYPH_COUNT = 256;
    localparam int GLYPH_COLS      = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int OFFSET_W    = 27;
    localparam int COLOR_W     = 24;

    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [13:0] RST_ROW_PITCH     = 14'd4096;
    localparam logic [2:0]  RST_BYTES_PER_PIX = 3'd4;
    localparam logic [1:0]  RST_COLOR_ORDER   = 2'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_ROW_PITCH     = 3'd2,
        REG_BYTES_PER_PIX = 3'd3,
        REG_COLOR_ORDER   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ORDER_RGB = 2'd0,
        ORDER_BGR = 2'd1
    } color_order_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_DRAW
    } ctrl_state_t;

    // input transaction payload, lowest field first in the bit order
    typedef struct packed {
        logic [3:0]         pad;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] fg_color;
        logic [11:0]        pos_y;
        logic [11:0]        pos_x;
        logic [7:0]         load_bits;
        logic [3:0]         load_row;
        logic [7:0]         char_code;
    } in_item_t;

    typedef struct packed {
        logic [4:0]                           pad;
        logic [GLYPH_COLS-1:0]                write_mask;
        logic [GLYPH_COLS-1:0][COLOR_W-1:0]   pixels;
        logic [OFFSET_W-1:0]                  row_offset;
    } out_item_t;

    typedef struct packed {
        logic font_wr;
        logic capture;
        logic base_set;
        logic issue;
    } grb_cmd_t;

    typedef struct packed {
        logic rd_busy;
        logic can_issue;
        logic issue_last;
    } grb_status_t;

endpackage

// File: rtl/glyph_row_blitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_blitter_unit
// Bitmap font character renderer: font row loads and glyph row emission.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) writes one glyph row into the font memory. A
// draw transaction (tuser 1) produces GLYPH_ROWS row results, top row first,
// each with its framebuffer byte offset, eight pixels and a write mask; tlast
// marks the final row. A draw goes through the offset multiply, then the base
// add, then one font memory read per row through a single read port; the next
// transaction waits until the last row has cleared the read stage. The output
// register lets the next transaction be taken while the last row waits. The
// font memory is not cleared at reset; draw only glyph rows that were loaded.
// Configuration writes are expected only while the block is idle.
module glyph_row_blitter_unit
    import grb_pkg::*;
#(
    parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // char_code, load_row, load_bits, pos_x, pos_y, fg_color, bg_color, pad
    input  logic [95:0]            s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // row_offset, pixel_0 .. pixel_7, write_mask, pad
    output logic [231:0]           m_axis_tdata,
    // last_row
    output logic                   m_axis_tlast
);

    grb_cmd_t    cmd;
    grb_status_t status;
    in_item_t    in_item;
    out_item_t   out_item;
    opcode_t     opcode;

    assign cfg_ready    = 1'b1;
    assign in_item      = in_item_t'(s_axis_tdata);
    assign opcode       = opcode_t'(s_axis_tuser);
    assign m_axis_tdata = out_item;

    grb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .opcode    (opcode),
        .cmd       (cmd),
        .status    (status)
    );

    grb_datapath #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_item    (in_item),
        .cmd        (cmd),
        .status     (status),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_item   (out_item),
        .out_tlast  (m_axis_tlast)
    );

endmodule

// File: rtl/grb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_ctrl
// Sequencer: takes load and draw transactions and steps through glyph rows.
// ----------------------------------------------------------------------------
module grb_ctrl
    import grb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_tvalid,
    output logic        in_tready,
    input  opcode_t     opcode,
    output grb_cmd_t    cmd,
    input  grb_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // wait until the last row has left the read stage
                in_tready = !status.rd_busy;
                if (in_tvalid && !status.rd_busy)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        cmd.font_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_BASE;
                    end
                end
            end
            ST_BASE:
            begin
                cmd.base_set = 1'b1;
                state_next   = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (status.can_issue)
                begin
                    cmd.issue = 1'b1;
                    if (status.issue_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/grb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grb_datapath
// Config registers, font memory, row offset arithmetic and the row pipeline.
// ----------------------------------------------------------------------------
module grb_datapath
    import grb_pkg::*;
#(
    parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  in_item_t               in_item,
    input  grb_cmd_t               cmd,
    output grb_status_t            status,
    input  logic                   out_tready,
    output logic                   out_tvalid,
    output out_item_t              out_item,
    output logic                   out_tlast
);

    localparam int DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    // configuration
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [13:0] pitch_reg;
    logic [2:0]  bpp_reg;
    logic [1:0]  order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            pitch_reg  <= RST_ROW_PITCH;
            bpp_reg    <= RST_BYTES_PER_PIX;
            order_reg  <= RST_COLOR_ORDER;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[12:0];
                REG_ROW_PITCH:     pitch_reg  <= cfg_data[13:0];
                REG_BYTES_PER_PIX: bpp_reg    <= cfg_data[2:0];
                REG_COLOR_ORDER:   order_reg  <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // glyph base address; codes at or above the glyph count wrap once
    logic [8:0]        code_mod;
    logic [ADDR_W-1:0] code_base;
    logic              load_ok;
    logic [ADDR_W-1:0] wr_addr;

    always_comb
    begin
        if ({1'b0, in_item.char_code} >= 9'(GLYPH_COUNT))
        begin
            code_mod = {1'b0, in_item.char_code} - 9'(GLYPH_COUNT);
        end
        else
        begin
            code_mod = {1'b0, in_item.char_code};
        end
        code_base = ADDR_W'(int'(code_mod) * GLYPH_ROWS);
        load_ok   = int'(in_item.load_row) < GLYPH_ROWS;
        wr_addr   = code_base + ADDR_W'(in_item.load_row);
    end

    // per character state
    logic [ADDR_W-1:0]     glyph_base_reg;
    logic [COLOR_W-1:0]    fg_reg;
    logic [COLOR_W-1:0]    bg_reg;
    logic [25:0]           prod_reg;
    logic [14:0]           xb_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [12:0]           ypos_reg;
    logic [GLYPH_COLS-1:0] xmask_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [GLYPH_COLS-1:0] xmask_next;

    always_comb
    begin
        for (int k = 0; k < GLYPH_COLS; k++)
        begin
            xmask_next[k] = (13'(in_item.pos_x) + 13'(k)) < width_reg;
        end
    end

    // read stage
    logic                  rd_valid_reg;
    logic [7:0]            rd_data_reg;
    logic [OFFSET_W-1:0]   rd_offset_reg;
    logic                  rd_yok_reg;
    logic                  rd_last_reg;
    logic                  rd_take;
    logic                  issue_last;
    logic [ADDR_W-1:0]     rd_addr;

    logic [7:0] font_mem [DEPTH];

    assign rd_take    = rd_valid_reg && (!out_tvalid || out_tready);
    assign issue_last = (row_reg == ROW_W'(GLYPH_ROWS - 1));
    assign rd_addr    = glyph_base_reg + ADDR_W'(row_reg);

    assign status.rd_busy    = rd_valid_reg;
    assign status.can_issue  = !rd_valid_reg || rd_take;
    assign status.issue_last = issue_last;

    always_ff @(posedge clk)
    begin
        if (cmd.font_wr && load_ok)
        begin
            font_mem[wr_addr] <= in_item.load_bits;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= font_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            glyph_base_reg <= code_base;
            fg_reg         <= in_item.fg_color;
            bg_reg         <= in_item.bg_color;
            prod_reg       <= 26'(in_item.pos_y) * 26'(pitch_reg);
            xb_reg         <= 15'(in_item.pos_x) * 15'(bpp_reg);
            ypos_reg       <= 13'(in_item.pos_y);
            xmask_reg      <= xmask_next;
            row_reg        <= '0;
        end
        if (cmd.base_set)
        begin
            offset_reg <= 27'(prod_reg) + 27'(xb_reg);
        end
        if (cmd.issue)
        begin
            rd_offset_reg <= offset_reg;
            rd_yok_reg    <= ypos_reg < height_reg;
            rd_last_reg   <= issue_last;
            offset_reg    <= offset_reg + 27'(pitch_reg);
            ypos_reg      <= ypos_reg + 13'd1;
            row_reg       <= row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            out_tvalid   <= 1'b0;
        end
        else
        begin
            if (cmd.issue)
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (rd_take)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_take)
            begin
                out_tvalid <= 1'b1;
            end
            else if (out_tready)
            begin
                out_tvalid <= 1'b0;
            end
        end
    end

    // colour into memory byte order, first byte lowest
    function automatic logic [COLOR_W-1:0] to_mem_order(input logic [COLOR_W-1:0] color,
                                                        input logic [1:0] order);
        logic [COLOR_W-1:0] res;
        res = '0;
        if (order == ORDER_RGB)
        begin
            res = {color[7:0], color[15:8], color[23:16]};
        end
        else if (order == ORDER_BGR)
        begin
            res = color;
        end
        return res;
    endfunction

    logic                  known;
    logic [COLOR_W-1:0]    fg_mem;
    logic [COLOR_W-1:0]    bg_mem;
    out_item_t             out_next;

    always_comb
    begin
        known  = (order_reg == ORDER_RGB) || (order_reg == ORDER_BGR);
        fg_mem = to_mem_order(fg_reg, order_reg);
        bg_mem = to_mem_order(bg_reg, order_reg);
        out_next            = '0;
        out_next.row_offset = rd_offset_reg;
        for (int k = 0; k < GLYPH_COLS; k++)
        begin
            // bit 7 of the glyph row is the leftmost pixel
            out_next.pixels[k] = rd_data_reg[GLYPH_COLS-1-k] ? fg_mem : bg_mem;
        end
        out_next.write_mask = (known && rd_yok_reg) ? xmask_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_take)
        begin
            out_item  <= out_next;
            out_tlast <= rd_last_reg;
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the glyph row blitter.
// Font rows are loaded and characters drawn over the input stream. Each draw
// is predicted as sixteen row results: byte offset, eight pixels in memory byte
// order and the write mask. The results are checked field by field as they
// leave the block. Runs cover several screen formats, including the degenerate
// ones, and several source and sink throttling phases.
// ----------------------------------------------------------------------------
module testbench;
    import grb_pkg::*;

    localparam int ROWS       = DEF_GLYPH_ROWS;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 30;

    // colour orders with no name in the package: nothing gets written
    localparam logic [1:0] ORDER_UNKNOWN = 2'd2;
    localparam logic [1:0] ORDER_SPARE   = 2'd3;

    typedef struct {
        out_item_t data;
        logic      is_last;
    } row_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [95:0]            s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [231:0]           m_axis_tdata;
    logic                   m_axis_tlast;

    // shadow of the block's registers and font memory
    logic [12:0] scr_width;
    logic [12:0] scr_height;
    logic [13:0] row_pitch;
    logic [2:0]  pix_bytes;
    logic [1:0]  pix_order;
    logic [7:0]  glyph_rows [256][ROWS];
    logic [15:0] row_loaded [256];
    logic [7:0]  drawable_codes [$];

    row_result_t pending_rows [$];
    int unsigned mismatches;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned quiet_cycles;

    glyph_row_blitter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 0xRRGGBB to memory byte order, first byte in bits 7:0
    function automatic logic [23:0] pack_color(input logic [23:0] rgb);
        if (pix_order == ORDER_RGB)
            return {rgb[7:0], rgb[15:8], rgb[23:16]};
        if (pix_order == ORDER_BGR)
            return rgb;
        return 24'd0;
    endfunction

    // font update or row rendering for one accepted transaction
    function automatic void render_item(input opcode_t op, input in_item_t it);
        row_result_t res;
        int unsigned ypos;
        logic [7:0]  shape;
        logic [23:0] fg_mem;
        logic [23:0] bg_mem;
        logic        known;
        if (op == OP_LOAD)
        begin
            glyph_rows[it.char_code][it.load_row] = it.load_bits;
            if (row_loaded[it.char_code] != 16'hFFFF)
            begin
                row_loaded[it.char_code][it.load_row] = 1'b1;
                if (row_loaded[it.char_code] == 16'hFFFF)
                    drawable_codes.push_back(it.char_code);
            end
            return;
        end
        fg_mem = pack_color(it.fg_color);
        bg_mem = pack_color(it.bg_color);
        known  = (pix_order == ORDER_RGB) || (pix_order == ORDER_BGR);
        for (int line = 0; line < ROWS; line++)
        begin
            ypos  = it.pos_y + line;
            shape = glyph_rows[it.char_code][line];
            res.data = '0;
            res.data.row_offset = 27'(ypos * row_pitch + it.pos_x * pix_bytes);
            for (int k = 0; k < GLYPH_COLS; k++)
            begin
                res.data.pixels[k] = shape[7-k] ? fg_mem : bg_mem;
                res.data.write_mask[k] = known && (ypos < scr_height)
                                         && ((it.pos_x + k) < scr_width);
            end
            res.is_last = (line == ROWS - 1);
            pending_rows.push_back(res);
        end
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input opcode_t op, input logic [7:0] code,
                             input logic [3:0] row, input logic [7:0] bits,
                             input logic [11:0] x, input logic [11:0] y,
                             input logic [23:0] fg, input logic [23:0] bg);
        in_item_t it;
        it = '{pad: '0, bg_color: bg, fg_color: fg, pos_y: y, pos_x: x,
               load_bits: bits, load_row: row, char_code: code};
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        render_item(op, it);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [13:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  scr_width  = value[12:0];
            REG_SCREEN_HEIGHT: scr_height = value[12:0];
            REG_ROW_PITCH:     row_pitch  = value;
            REG_BYTES_PER_PIX: pix_bytes  = value[2:0];
            REG_COLOR_ORDER:   pix_order  = value[1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [13:0] w, input logic [13:0] h,
                                input logic [13:0] pitch, input logic [2:0] bpp,
                                input logic [1:0] order);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_ROW_PITCH, pitch);
        write_reg(REG_BYTES_PER_PIX, {11'd0, bpp});
        write_reg(REG_COLOR_ORDER, {12'd0, order});
        cfg_valid <= 1'b0;
    endtask

    // all rows out, then margin for a load still in flight
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // biased towards the screen edge so that masks get clipped
    function automatic logic [11:0] pick_coord(input int unsigned limit);
        int unsigned v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 4095);
            1:       v = $urandom_range(0, 31);
            default: v = limit - 9 + $urandom_range(0, 10);
        endcase
        return v[11:0];
    endfunction

    task automatic test_defaults();
        logic [7:0] pattern [ROWS];
        pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h18, 8'h24, 8'h42, 8'h7E,
                    8'h81, 8'hAA, 8'h55, 8'hC3, 8'h3C, 8'hF0, 8'h0F, 8'h00};
        for (int r = 0; r < ROWS; r++)
            send_item(OP_LOAD, 8'h41, r[3:0], pattern[r], 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)), 24'($urandom_range(0, 24'hFFFFFF)),
                      24'($urandom_range(0, 24'hFFFFFF)));
        send_item(OP_DRAW, 8'h41, 4'd0, 8'd0, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000);
        send_item(OP_DRAW, 8'h41, 4'hF, 8'hFF, 12'hFFF, 12'hFFF, 24'h000000, 24'hFFFFFF);
        send_item(OP_DRAW, 8'h41, 4'd5, 8'h5A, 12'd1020, 12'd760, 24'h123456, 24'hABCDEF);
        send_item(OP_DRAW, 8'h41, 4'd9, 8'hA5, 12'd1016, 12'd752, 24'hFF0000, 24'h00FF00);
        wait_idle();
    endtask

    task automatic test_format_extremes();
        // zero width, widest stride and pitch
        apply_config(14'd0, 14'd768, 14'd16383, 3'd7, ORDER_RGB);
        send_item(OP_DRAW, 8'h41, 4'd0, 8'd0, 12'hFFF, 12'hFFF, 24'h0000FF, 24'hFF00FF);
        wait_idle();
        // zero height, zero stride, blue first
        apply_config(14'd4096, 14'd0, 14'd1, 3'd0, ORDER_BGR);
        send_item(OP_DRAW, 8'h41, 4'd0, 8'd0, 12'd3, 12'd0, 24'hC0FFEE, 24'h102030);
        wait_idle();
        apply_config(14'd1024, 14'd768, 14'd4096, 3'd4, ORDER_UNKNOWN);
        send_item(OP_DRAW, 8'h41, 4'd0, 8'd0, 12'd8, 12'd8, 24'hFFFFFF, 24'h808080);
        wait_idle();
        apply_config(14'd8191, 14'd8191, 14'd0, 3'd3, ORDER_SPARE);
        send_item(OP_DRAW, 8'h41, 4'd0, 8'd0, 12'd100, 12'd9, 24'h010203, 24'h040506);
        wait_idle();
        // one visible pixel only
        apply_config(14'd1, 14'd1, 14'd1, 3'd3, ORDER_BGR);
        send_item(OP_DRAW, 8'h41, 4'd0, 8'd0, 12'd0, 12'd0, 24'h00FF00, 24'h0000FF);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned seg_width  [8] = '{1024, 640, 0, 8191, 1, 4096, 200, 333};
        int unsigned seg_height [8] = '{768, 480, 100, 8191, 1, 4096, 50, 0};
        int unsigned seg_pitch  [8] = '{4096, 1920, 16383, 0, 1, 16383, 800, 1000};
        int unsigned seg_bpp    [8] = '{4, 3, 7, 0, 3, 4, 4, 5};
        logic [1:0]  seg_order  [8] = '{ORDER_RGB, ORDER_BGR, ORDER_UNKNOWN, ORDER_BGR,
                                        ORDER_SPARE, ORDER_RGB, ORDER_BGR, ORDER_RGB};
        int unsigned idle_pct   [4] = '{0, 75, 0, 29};
        int unsigned stall_pct  [4] = '{0, 0, 75, 29};
        int unsigned sent;
        int unsigned choice;
        logic [7:0]  code;
        for (int seg = 0; seg < 8; seg++)
        begin
            wait_idle();
            apply_config(14'(seg_width[seg]), 14'(seg_height[seg]), 14'(seg_pitch[seg]),
                         3'(seg_bpp[seg]), seg_order[seg]);
            src_idle_pct   = idle_pct[seg % 4];
            sink_stall_pct = stall_pct[seg % 4];
            sent = 0;
            while (sent < 40)
            begin
                choice = $urandom_range(0, 9);
                if (choice < 1 || drawable_codes.size() == 0)
                begin
                    // whole glyph, then it can be drawn
                    code = 8'($urandom_range(0, 255));
                    for (int r = 0; r < ROWS; r++)
                        send_item(OP_LOAD, code, r[3:0], 8'($urandom_range(0, 255)),
                                  12'($urandom_range(0, 4095)),
                                  12'($urandom_range(0, 4095)),
                                  24'($urandom_range(0, 24'hFFFFFF)),
                                  24'($urandom_range(0, 24'hFFFFFF)));
                    sent += ROWS;
                end
                else if (choice < 3)
                begin
                    send_item(OP_LOAD, 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                              24'($urandom_range(0, 24'hFFFFFF)),
                              24'($urandom_range(0, 24'hFFFFFF)));
                    sent++;
                end
                else
                begin
                    code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
                    send_item(OP_DRAW, code, 4'($urandom_range(0, 15)),
                              8'($urandom_range(0, 255)),
                              pick_coord(scr_width), pick_coord(scr_height),
                              24'($urandom_range(0, 24'hFFFFFF)),
                              24'($urandom_range(0, 24'hFFFFFF)));
                    sent++;
                end
            end
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
    begin : check_rows
        out_item_t   got;
        row_result_t want;
        logic        bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row: off=%h px=%h mask=%h last=%b",
                             got.row_offset, got.pixels, got.write_mask, m_axis_tlast);
            end
            else
            begin
                want = pending_rows.pop_front();
                bad = (got.row_offset !== want.data.row_offset)
                      || (got.write_mask !== want.data.write_mask)
                      || (m_axis_tlast !== want.is_last);
                for (int k = 0; k < GLYPH_COLS; k++)
                    bad |= (got.pixels[k] !== want.data.pixels[k]);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: exp off=%h px=%h mask=%h last=%b / got off=%h px=%h mask=%h last=%b",
                                 want.data.row_offset, want.data.pixels,
                                 want.data.write_mask, want.is_last, got.row_offset,
                                 got.pixels, got.write_mask, m_axis_tlast);
                end
            end
        end
    end

    // any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_LOAD;
        quiet_cycles   = 0;
        mismatches     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        scr_width      = RST_SCREEN_WIDTH;
        scr_height     = RST_SCREEN_HEIGHT;
        row_pitch      = RST_ROW_PITCH;
        pix_bytes      = RST_BYTES_PER_PIX;
        pix_order      = RST_COLOR_ORDER;
        for (int c = 0; c < 256; c++)
            row_loaded[c] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_defaults();
        test_format_extremes();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
